FILE: hdl/absolute_encoder_unwrap_rate_avg_macros.svh
// Assertion helpers for the encoder unwrap block.
`ifndef ABSOLUTE_ENCODER_UNWRAP_RATE_AVG_MACROS_SVH
`define ABSOLUTE_ENCODER_UNWRAP_RATE_AVG_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AEU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AEU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/aeu_pkg.sv
package aeu_pkg;

	localparam int ENC_BITS   = 13;
	localparam int RATE_DEPTH = 8;

	localparam int READ_W    = 13;
	localparam int THR_W     = 13;
	localparam int INIT_W    = 8;
	localparam int TURN_W    = 16;
	localparam int POS_W     = 30;
	localparam int OUT_SPD_W = 14;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 13;

	localparam int SPD_W  = ENC_BITS + 1;
	localparam int CMP_W  = ((ENC_BITS > THR_W) ? ENC_BITS : THR_W) + 2;
	localparam int SUM_W  = SPD_W + $clog2(RATE_DEPTH);
	localparam int FILL_W = $clog2(RATE_DEPTH + 1);
	localparam int SLOT_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(SUM_W + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CMP_W-1:0] MODULUS = CMP_W'(1 << ENC_BITS);

	localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INIT_FRAMES    = CFG_IDX_W'(1);

	localparam logic [THR_W-1:0]  WRAP_THRESHOLD_RST = THR_W'(4096);
	localparam logic [INIT_W-1:0] INIT_FRAMES_RST    = INIT_W'(10);

	typedef struct packed {
		logic signed [TURN_W-1:0] turns;
		logic        [POS_W-1:0]  position;
		logic signed [SPD_W-1:0]  speed;
		logic                     ready;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic pop;
		logic load;
	} bk_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOAD,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

FILE: hdl/aeu_front.sv
module aeu_front
	import aeu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [READ_W-1:0] reading,
	input  logic [THR_W-1:0]  wrap_threshold,
	input  logic [INIT_W-1:0] init_frames,
	input  q_stat_t           q_stat,
	output logic              push,
	output item_t             push_item
);

	logic [ENC_BITS-1:0]      prev_q;
	logic [ENC_BITS-1:0]      bias_q;
	logic [INIT_W-1:0]        frames_q;
	logic signed [TURN_W-1:0] turns_q;

	logic [ENC_BITS-1:0]      rd;
	logic                     take_bias;
	logic [ENC_BITS-1:0]      bias_new;
	logic [INIT_W-1:0]        frames_new;
	logic signed [CMP_W-1:0]  diff;
	logic signed [CMP_W-1:0]  thr_s;
	logic                     wrap_dn;
	logic                     wrap_up;
	logic [CMP_W-1:0]         speed_w;
	logic signed [TURN_W-1:0] turns_new;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		rd         = ENC_BITS'(reading);
		take_bias  = frames_q < init_frames;
		bias_new   = take_bias ? rd : bias_q;
		frames_new = take_bias ? frames_q + INIT_W'(1) : frames_q;
		diff       = $signed(CMP_W'(rd)) - $signed(CMP_W'(prev_q));
		thr_s      = $signed(CMP_W'(wrap_threshold));
		wrap_dn    = diff > thr_s;
		wrap_up    = diff < -thr_s;
		if (wrap_dn) begin
			speed_w   = diff - MODULUS;
			turns_new = turns_q - TURN_W'(1);
		end else if (wrap_up) begin
			speed_w   = diff + MODULUS;
			turns_new = turns_q + TURN_W'(1);
		end else begin
			speed_w   = diff;
			turns_new = turns_q;
		end
		push_item.turns    = turns_new;
		push_item.position = (POS_W'(turns_new) << ENC_BITS) + POS_W'(rd) - POS_W'(bias_new);
		push_item.speed    = SPD_W'(speed_w);
		push_item.ready    = frames_new >= init_frames;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			bias_q   <= '0;
			frames_q <= '0;
			turns_q  <= '0;
		end else if (push) begin
			prev_q   <= rd;
			bias_q   <= bias_new;
			frames_q <= frames_new;
			turns_q  <= turns_new;
		end
	end

endmodule

FILE: hdl/aeu_queue.sv
module aeu_queue
	import aeu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head_item,
	output q_stat_t q_stat
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_item    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: hdl/aeu_back.sv
module aeu_back
	import aeu_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  item_t                       head_item,
	input  q_stat_t                     q_stat,
	output bk_stat_t                    bk_stat,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [TURN_W-1:0]    turns,
	output logic signed [POS_W-1:0]     position,
	output logic signed [OUT_SPD_W-1:0] speed_raw,
	output logic signed [OUT_SPD_W-1:0] speed_avg,
	output logic                        ready_res
);

	bk_state_t               state_q;
	bk_state_t               state_d;

	logic signed [SPD_W-1:0] ring_q [RATE_DEPTH];
	logic [FILL_W-1:0]       fill_q;
	logic [SLOT_W-1:0]       slot_q;
	logic signed [SUM_W-1:0] sum_q;

	item_t                   item_s1;
	logic [SUM_W-1:0]        mag_q;
	logic [FILL_W-1:0]       rem_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;

	logic                    ring_full;
	logic signed [SPD_W-1:0] old_speed;
	logic [FILL_W:0]         trial;
	logic                    q_bit;
	logic [SUM_W-1:0]        quot;
	logic                    out_free;
	logic                    pop;
	logic                    load;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) state_d = BK_LOAD;
			end
			BK_LOAD: state_d = BK_DIV;
			BK_DIV: begin
				if (cnt_q == '0) state_d = BK_OUT;
			end
			BK_OUT: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		case (state_q)
			BK_IDLE: pop = !q_stat.empty;
			BK_OUT:  load = out_free;
			default: begin
				pop  = 1'b0;
				load = 1'b0;
			end
		endcase
		bk_stat.pop  = pop;
		bk_stat.load = load;
	end

	always_comb begin
		ring_full = fill_q == FILL_W'(RATE_DEPTH);
		old_speed = ring_full ? ring_q[slot_q] : '0;
		trial     = {rem_q, mag_q[SUM_W-1]};
		q_bit     = trial >= {1'b0, fill_q};
		quot      = neg_q ? -mag_q : mag_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ring_q[slot_q] <= head_item.speed;
			item_s1        <= head_item;
		end
		if (state_q == BK_LOAD) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			rem_q <= '0;
			cnt_q <= CNT_W'(SUM_W - 1);
		end
		if (state_q == BK_DIV) begin
			rem_q <= q_bit ? FILL_W'(trial - {1'b0, fill_q}) : FILL_W'(trial);
			mag_q <= {mag_q[SUM_W-2:0], q_bit};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (load) begin
			turns     <= item_s1.turns;
			position  <= $signed(item_s1.position);
			speed_raw <= OUT_SPD_W'(item_s1.speed);
			speed_avg <= $signed(OUT_SPD_W'(quot));
			ready_res <= item_s1.ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			fill_q      <= '0;
			slot_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				sum_q  <= sum_q + SUM_W'(head_item.speed) - SUM_W'(old_speed);
				fill_q <= ring_full ? fill_q : fill_q + FILL_W'(1);
				slot_q <= (slot_q == SLOT_W'(RATE_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/absolute_encoder_unwrap_rate_avg.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    reading
// out       output     out_valid / out_stall  turns, position, speed_raw, speed_avg, ready_res
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted sample is unwrapped in its accept cycle and queued; the averaging side then
// takes one sample at a time through the pop, load, divide and output states, the divide
// being a one-bit-per-cycle restoring division of the window sum by the fill count.
// The two-entry queue holds samples while the divider or a stalled output is busy.
// Asynchronous active-low reset clears control state but not the speed ring or data registers.
// Config writes are always ready.
`include "absolute_encoder_unwrap_rate_avg_macros.svh"

module absolute_encoder_unwrap_rate_avg
	import aeu_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [READ_W-1:0]           reading,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [TURN_W-1:0]    turns,
	output logic signed [POS_W-1:0]     position,
	output logic signed [OUT_SPD_W-1:0] speed_raw,
	output logic signed [OUT_SPD_W-1:0] speed_avg,
	output logic                        ready_res,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data
);

	logic [THR_W-1:0]  wrap_threshold_q;
	logic [INIT_W-1:0] init_frames_q;

	q_stat_t  q_stat;
	bk_stat_t bk_stat;
	logic     push;
	item_t    push_item;
	item_t    head_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_threshold_q <= WRAP_THRESHOLD_RST;
			init_frames_q    <= INIT_FRAMES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WRAP_THRESHOLD: wrap_threshold_q <= THR_W'(cfg_data);
				REG_INIT_FRAMES:    init_frames_q    <= INIT_W'(cfg_data);
				default:            ;
			endcase
		end
	end

	aeu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.reading        (reading),
		.wrap_threshold (wrap_threshold_q),
		.init_frames    (init_frames_q),
		.q_stat         (q_stat),
		.push           (push),
		.push_item      (push_item)
	);

	aeu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (bk_stat.pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	aeu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.q_stat    (q_stat),
		.bk_stat   (bk_stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.turns     (turns),
		.position  (position),
		.speed_raw (speed_raw),
		.speed_avg (speed_avg),
		.ready_res (ready_res)
	);

	`AEU_ASSERT_SAME(a_push_room, push, !q_stat.full, "sample pushed into a full queue")
	`AEU_ASSERT_SAME(a_pop_data, bk_stat.pop, !q_stat.empty, "sample popped from an empty queue")
	`AEU_ASSERT_NEXT(a_load_shown, bk_stat.load, out_valid, "loaded result not presented")

endmodule

FILE: tb/sv/encoder_unwrap_checker.sv
`timescale 1ns / 1ps

module encoder_unwrap_checker
	import aeu_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [READ_W-1:0]           reading,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic signed [TURN_W-1:0]    turns,
	input  logic signed [POS_W-1:0]     position,
	input  logic signed [OUT_SPD_W-1:0] speed_raw,
	input  logic signed [OUT_SPD_W-1:0] speed_avg,
	input  logic                        ready_res,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	output int                          fail_count,
	output int                          pending
);

	typedef struct {
		logic signed [TURN_W-1:0]    turns;
		logic signed [POS_W-1:0]     position;
		logic signed [OUT_SPD_W-1:0] speed_raw;
		logic signed [OUT_SPD_W-1:0] speed_avg;
		logic                        ready;
	} unwrap_res_t;

	logic [THR_W-1:0]    wrap_thr;
	logic [INIT_W-1:0]   bias_frames;
	logic [INIT_W-1:0]   frames_taken;
	logic [ENC_BITS-1:0] last_count;
	logic [ENC_BITS-1:0] zero_count;
	logic [TURN_W-1:0]   turn_cnt;
	int                  speed_hist [RATE_DEPTH];
	int                  hist_fill;
	int                  hist_slot;
	int                  speed_sum;
	int                  mismatches;
	unwrap_res_t         due_results [$];
	unwrap_res_t         due;

	function automatic unwrap_res_t unwrap_sample(input logic [READ_W-1:0] raw);
		unwrap_res_t r;
		int          cnt;
		int          diff;
		int          spd;
		int          avg;
		longint      pos;
		cnt = int'(raw) & ((1 << ENC_BITS) - 1);
		if (frames_taken < bias_frames) begin
			zero_count = cnt[ENC_BITS-1:0];
			frames_taken++;
		end
		diff = cnt - int'(last_count);
		last_count = cnt[ENC_BITS-1:0];
		if (diff > int'(wrap_thr)) begin
			spd = diff - (1 << ENC_BITS);
			turn_cnt--;
		end else if (diff < -int'(wrap_thr)) begin
			spd = diff + (1 << ENC_BITS);
			turn_cnt++;
		end else begin
			spd = diff;
		end
		if (hist_fill < RATE_DEPTH) begin
			speed_hist[hist_slot] = spd;
			speed_sum += spd;
			hist_fill++;
		end else begin
			speed_sum += spd - speed_hist[hist_slot];
			speed_hist[hist_slot] = spd;
		end
		hist_slot = (hist_slot + 1) % RATE_DEPTH;
		avg = speed_sum / hist_fill;
		pos = longint'($signed(turn_cnt)) * (longint'(1) << ENC_BITS) + cnt - int'(zero_count);
		r.turns     = turn_cnt;
		r.position  = pos[POS_W-1:0];
		r.speed_raw = spd[OUT_SPD_W-1:0];
		r.speed_avg = avg[OUT_SPD_W-1:0];
		r.ready     = frames_taken >= bias_frames;
		return r;
	endfunction

	task automatic check_field(input string fld, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fld, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_thr     = WRAP_THRESHOLD_RST;
			bias_frames  = INIT_FRAMES_RST;
			frames_taken = '0;
			last_count   = '0;
			zero_count   = '0;
			turn_cnt     = '0;
			hist_fill    = 0;
			hist_slot    = 0;
			speed_sum    = 0;
			mismatches   = 0;
			due_results.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WRAP_THRESHOLD: wrap_thr = cfg_data[THR_W-1:0];
					REG_INIT_FRAMES:    bias_frames = cfg_data[INIT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				due_results.push_back(unwrap_sample(reading));
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("result transaction with no sample pending");
					mismatches++;
				end else begin
					due = due_results.pop_front();
					check_field("turns", due.turns, turns);
					check_field("position", due.position, position);
					check_field("speed_raw", due.speed_raw, speed_raw);
					check_field("speed_avg", due.speed_avg, speed_avg);
					check_field("ready_res", due.ready, ready_res);
				end
			end
			fail_count <= mismatches;
			pending    <= due_results.size();
		end
	end

endmodule

FILE: tb/sv/absolute_encoder_unwrap_rate_avg_tb.sv
`timescale 1ns / 1ps

module absolute_encoder_unwrap_rate_avg_tb;
	import aeu_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 160;
	localparam int TAIL_CYCLES    = 40;

	logic                        clk;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic [READ_W-1:0]           reading   = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [TURN_W-1:0]    turns;
	logic signed [POS_W-1:0]     position;
	logic signed [OUT_SPD_W-1:0] speed_raw;
	logic signed [OUT_SPD_W-1:0] speed_avg;
	logic                        ready_res;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DAT_W-1:0]        cfg_data  = '0;

	int                fail_count;
	int                pending;
	int                tx_idle_pct  = 0;
	int                rx_stall_pct = 0;
	bit                hold_req     = 1'b0;
	int                quiet_cycles = 0;
	logic [READ_W-1:0] last_sent    = '0;

	int opening_run [12] = '{8191, 0, 4096, 0, 4097, 0, 8191, 8190, 1, 5461, 2730, 12};
	int lowered_run [2]  = '{100, 200};
	int tight_run   [4]  = '{0, 1, 0, 8191};
	int loose_run   [3]  = '{0, 8191, 0};

	absolute_encoder_unwrap_rate_avg DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.reading   (reading),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.turns     (turns),
		.position  (position),
		.speed_raw (speed_raw),
		.speed_avg (speed_avg),
		.ready_res (ready_res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	encoder_unwrap_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.reading    (reading),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.turns      (turns),
		.position   (position),
		.speed_raw  (speed_raw),
		.speed_avg  (speed_avg),
		.ready_res  (ready_res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("absolute_encoder_unwrap_rate_avg_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_reading(input logic [READ_W-1:0] rd);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		reading  <= rd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		last_sent = rd;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DAT_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_settings(input int thr, input int frames);
		write_reg(REG_WRAP_THRESHOLD, thr);
		write_reg(REG_INIT_FRAMES, frames);
		cfg_valid <= 1'b0;
	endtask

	// mostly smooth motion around the turn, some jumps and end-of-range readings
	function automatic logic [READ_W-1:0] next_reading();
		int pick;
		int span;
		int step;
		pick = $urandom_range(99);
		span = ($urandom_range(3) == 0) ? 6000 : 1500;
		step = int'($urandom_range(2 * span)) - span;
		if (pick < 70)
			return READ_W'(int'(last_sent) + step);
		else if (pick < 85)
			return READ_W'($urandom_range((1 << READ_W) - 1));
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			2:       return READ_W'(4095);
			default: return READ_W'(4096);
		endcase
	endfunction

	initial begin
		int p;
		int i;
		int thr;
		int frames;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_run[k]) send_reading(READ_W'(opening_run[k]));
		wait_drained();
		apply_settings(4096, 3);
		foreach (lowered_run[k]) send_reading(READ_W'(lowered_run[k]));
		wait_drained();
		apply_settings(0, 0);
		foreach (tight_run[k]) send_reading(READ_W'(tight_run[k]));
		wait_drained();
		apply_settings(8191, 255);
		foreach (loose_run[k]) send_reading(READ_W'(loose_run[k]));

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p % 6)
				0:       thr = 8191;
				1:       thr = 0;
				2:       thr = 4096;
				default: thr = $urandom_range(8191);
			endcase
			case (p % 5)
				0:       frames = 255;
				1:       frames = 1;
				2:       frames = 0;
				default: frames = $urandom_range(1, 255);
			endcase
			apply_settings(thr, frames);
			case (p % 4)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct  = 46;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 46;
				end
				default: begin
					tx_idle_pct  = 27;
					rx_stall_pct = 27;
				end
			endcase
			// hold the output while samples keep coming
			if (p == 4)
				hold_req = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && p % 3 == 1)
					wait_drained();
				send_reading(next_reading());
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("absolute_encoder_unwrap_rate_avg_tb OK");
		else
			$display("absolute_encoder_unwrap_rate_avg_tb NOT OK");
		$finish;
	end

endmodule
